// File: rtl/wml_pkg.sv
// Shared constants and types of the weighted median location core.
`default_nettype none

package wml_pkg;

   localparam int COORD_RANGE = 32768;
   localparam int ADDR_W      = $clog2(COORD_RANGE);
   localparam int COORD_W     = 15;
   localparam int WEIGHT_IN_W = 20;
   localparam int WEIGHT_W    = 40;
   localparam int COST_W      = 62;
   localparam int PROD_W      = WEIGHT_W + ADDR_W;

   localparam logic [ADDR_W-1:0]   LAST_IDX   = ADDR_W'(COORD_RANGE - 1);
   localparam logic [COST_W-1:0]   EMPTY_COST = COST_W'(1) << 61;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

   typedef enum logic {
      ACT_ADD     = 1'b0,
      ACT_COMPUTE = 1'b1
   } wml_action_type;

   typedef enum logic {
      ACC_PRODUCT = 1'b0,
      ACC_LEFT    = 1'b1
   } wml_acc_sel_type;

   typedef struct packed {
      logic            mul_en;
      wml_acc_sel_type acc_sel;
   } wml_alu_ctl_type;

endpackage

`default_nettype wire

// File: rtl/wml_alu.sv
// Shared arithmetic unit: registered multiplier, saturating weight adder, cost adder/compare.
`default_nettype none

module wml_alu (
   input  logic                                clock,
   input  wml_pkg::wml_alu_ctl_type            ctl,
   input  logic [wml_pkg::WEIGHT_W-1:0]        mul_a,
   input  logic [wml_pkg::ADDR_W-1:0]          mul_b,
   input  logic [wml_pkg::WEIGHT_W-1:0]        sat_a,
   input  logic [wml_pkg::WEIGHT_W-1:0]        sat_b,
   input  logic [wml_pkg::COST_W-1:0]          acc_a,
   input  logic [wml_pkg::COST_W-1:0]          left,
   input  logic [wml_pkg::COST_W-1:0]          best,
   output logic [wml_pkg::WEIGHT_W-1:0]        sat_sum,
   output logic [wml_pkg::COST_W-1:0]          acc_sum,
   output logic                                acc_le
);
   import wml_pkg::*;

   logic [PROD_W-1:0]   product_ff;
   logic [WEIGHT_W:0]   raw_sum;
   logic [COST_W-1:0]   acc_b;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         product_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
   end

   assign raw_sum = {1'b0, sat_a} + {1'b0, sat_b};
   assign sat_sum = raw_sum[WEIGHT_W] ? WEIGHT_MAX : raw_sum[WEIGHT_W-1:0];

   assign acc_b   = (ctl.acc_sel == ACC_LEFT) ? left : COST_W'(product_ff);
   assign acc_sum = acc_a + acc_b;
   assign acc_le  = (acc_sum <= best);

endmodule

`default_nettype wire

// File: rtl/weighted_median_location_core.sv
// Top level: sequencer, weight and left-cost memories around the shared arithmetic unit.
`default_nettype none

// Weighted median location core. An add transaction (req_action = 0) accumulates
// req_weight into the weight kept for req_coordinate; it holds busy after
// acceptance (read, then saturating write back). A compute transaction (req_action = 1)
// walks every coordinate upward and then downward through the single-port weight memory,
// using one shared multiplier and adder: each coordinate is read; an occupied one is
// multiplied and accumulated, and on the way down also compared. Then rsp_valid pulses
// for one cycle with the best coordinate and its cost. The result
// cannot be held off by the receiver; it must be captured in that cycle. The downward
// walk zeroes the weights for the next batch. After reset the block clears the weight
// memory, one entry a cycle, and holds busy until every entry is cleared.
module weighted_median_location_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [wml_pkg::COORD_W-1:0]       req_coordinate,
   input  logic [wml_pkg::WEIGHT_IN_W-1:0]   req_weight,
   output logic                              rsp_valid,
   output logic [wml_pkg::COORD_W-1:0]       rsp_best_coordinate,
   output logic [wml_pkg::COST_W-1:0]        rsp_min_cost
);
   import wml_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_UP_RD,
      ST_UP_MUL,
      ST_UP_ACC,
      ST_DN_RD,
      ST_DN_MUL,
      ST_DN_ACC,
      ST_DN_CMP,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [ADDR_W-1:0]       idx_ff;
   logic [ADDR_W-1:0]       prev_ff;
   logic [ADDR_W-1:0]       op_coord_ff;
   logic [WEIGHT_IN_W-1:0]  op_weight_ff;
   logic [WEIGHT_W-1:0]     sum_ff;
   logic [COST_W-1:0]       cost_ff;
   logic [COST_W-1:0]       best_ff;
   logic [ADDR_W-1:0]       best_at_ff;
   logic                    found_ff;
   logic                    rsp_valid_ff;
   logic [COORD_W-1:0]      rsp_coord_ff;
   logic [COST_W-1:0]       rsp_cost_ff;

   // memories
   logic [WEIGHT_W-1:0]     weight_mem [COORD_RANGE];
   logic [COST_W-1:0]       left_mem   [COORD_RANGE];
   logic [WEIGHT_W-1:0]     w_rd_ff;
   logic [COST_W-1:0]       lc_rd_ff;

   logic                    w_we, w_re, lc_we, lc_re;
   logic [ADDR_W-1:0]       w_waddr, w_raddr;
   logic [WEIGHT_W-1:0]     w_wdata;

   wml_alu_ctl_type         alu_ctl;
   logic [ADDR_W-1:0]       span;
   logic [WEIGHT_W-1:0]     sat_a, sat_b, sat_sum;
   logic [COST_W-1:0]       acc_sum;
   logic                    acc_le;

   logic                    accept;
   logic                    in_range;
   logic                    idx_last, idx_first, w_nz;

   assign accept    = start && (state_ff == ST_IDLE);
   assign in_range  = (32'(req_coordinate) < COORD_RANGE);
   assign idx_last  = (idx_ff == LAST_IDX);
   assign idx_first = (idx_ff == '0);
   assign w_nz      = (w_rd_ff != '0);

   always_comb begin
      w_we    = 1'b0;
      w_waddr = idx_ff;
      w_wdata = '0;
      w_re    = 1'b0;
      w_raddr = idx_ff;
      lc_we   = 1'b0;
      lc_re   = 1'b0;
      alu_ctl = '{mul_en: 1'b0, acc_sel: ACC_PRODUCT};
      span    = prev_ff - idx_ff;
      sat_a   = sum_ff;
      sat_b   = w_rd_ff;
      case (state_ff)
         ST_CLEAR: begin
            w_we = 1'b1;
         end
         ST_IDLE: begin
            w_re    = start;
            w_raddr = ADDR_W'(req_coordinate);
         end
         ST_ADD: begin
            w_we    = 1'b1;
            w_waddr = op_coord_ff;
            sat_a   = w_rd_ff;
            sat_b   = WEIGHT_W'(op_weight_ff);
            w_wdata = sat_sum;
         end
         ST_UP_RD: begin
            w_re = 1'b1;
         end
         ST_UP_MUL: begin
            span           = idx_ff - prev_ff;
            alu_ctl.mul_en = w_nz;
         end
         ST_UP_ACC: begin
            lc_we = 1'b1;
         end
         ST_DN_RD: begin
            // read-first: old weight is captured while the entry is zeroed
            w_re  = 1'b1;
            lc_re = 1'b1;
            w_we  = 1'b1;
         end
         ST_DN_MUL: begin
            alu_ctl.mul_en = w_nz;
         end
         ST_DN_CMP: begin
            alu_ctl.acc_sel = ACC_LEFT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= w_wdata;
      end
      if (w_re) begin
         w_rd_ff <= weight_mem[w_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (lc_we) begin
         left_mem[idx_ff] <= acc_sum;
      end
      if (lc_re) begin
         lc_rd_ff <= left_mem[idx_ff];
      end
   end

   wml_alu u_alu (
      .clock   (clock),
      .ctl     (alu_ctl),
      .mul_a   (sum_ff),
      .mul_b   (span),
      .sat_a   (sat_a),
      .sat_b   (sat_b),
      .acc_a   (cost_ff),
      .left    (lc_rd_ff),
      .best    (best_ff),
      .sat_sum (sat_sum),
      .acc_sum (acc_sum),
      .acc_le  (acc_le)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_EMIT);
         case (state_ff)
            ST_CLEAR: begin
               if (idx_last) begin
                  idx_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (req_action == ACT_COMPUTE) begin
                     idx_ff     <= '0;
                     prev_ff    <= '0;
                     sum_ff     <= '0;
                     cost_ff    <= '0;
                     found_ff   <= 1'b0;
                     best_ff    <= EMPTY_COST;
                     best_at_ff <= LAST_IDX;
                     state_ff   <= ST_UP_RD;
                  end else if (in_range) begin
                     op_coord_ff  <= ADDR_W'(req_coordinate);
                     op_weight_ff <= req_weight;
                     state_ff     <= ST_ADD;
                  end
               end
            end
            ST_ADD: begin
               state_ff <= ST_IDLE;
            end
            ST_UP_RD: begin
               state_ff <= ST_UP_MUL;
            end
            ST_UP_MUL, ST_UP_ACC: begin
               if (state_ff == ST_UP_MUL && w_nz) begin
                  state_ff <= ST_UP_ACC;
               end else if (idx_last) begin
                  // turn around for the downward pass
                  sum_ff   <= '0;
                  cost_ff  <= '0;
                  prev_ff  <= LAST_IDX;
                  state_ff <= ST_DN_RD;
               end else begin
                  if (state_ff == ST_UP_ACC) begin
                     cost_ff <= acc_sum;
                     sum_ff  <= sat_sum;
                     prev_ff <= idx_ff;
                  end
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_UP_RD;
               end
            end
            ST_DN_RD: begin
               state_ff <= ST_DN_MUL;
            end
            ST_DN_ACC: begin
               cost_ff  <= acc_sum;
               sum_ff   <= sat_sum;
               prev_ff  <= idx_ff;
               state_ff <= ST_DN_CMP;
            end
            ST_DN_MUL, ST_DN_CMP: begin
               if (state_ff == ST_DN_MUL && w_nz) begin
                  state_ff <= ST_DN_ACC;
               end else begin
                  // ties go to the lower coordinate, which is visited later
                  if (state_ff == ST_DN_CMP && (!found_ff || acc_le)) begin
                     best_ff    <= acc_sum;
                     best_at_ff <= idx_ff;
                     found_ff   <= 1'b1;
                  end
                  if (idx_first) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     idx_ff   <= idx_ff - 1'b1;
                     state_ff <= ST_DN_RD;
                  end
               end
            end
            ST_EMIT: begin
               rsp_coord_ff <= COORD_W'(best_at_ff);
               rsp_cost_ff  <= best_ff;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_best_coordinate = rsp_coord_ff;
   assign rsp_min_cost        = rsp_cost_ff;

endmodule

`default_nettype wire

// File: rtl/wml_checker.sv
// Port-level checks of the weighted median location core, bound to the top level.
`default_nettype none

module wml_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              req_action,
   input  logic                              rsp_valid,
   input  logic [wml_pkg::COORD_W-1:0]       rsp_best_coordinate,
   input  logic [wml_pkg::COST_W-1:0]        rsp_min_cost
);
   import wml_pkg::*;

   // result strobe lasts a single cycle
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   // a result only ends a busy stretch
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding busy period");

   // a compute transaction keeps the block busy
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_COMPUTE)) |=> busy)
      else $error("compute transaction did not raise busy");

   // cost never exceeds the empty marker
   a_cost_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_cost <= EMPTY_COST))
      else $error("result cost out of range");

   // empty batch reports the top coordinate
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_min_cost == EMPTY_COST)) |->
         (rsp_best_coordinate == COORD_W'(COORD_RANGE - 1)))
      else $error("empty result with wrong coordinate");

endmodule

bind weighted_median_location_core wml_checker u_wml_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_action          (req_action),
   .rsp_valid           (rsp_valid),
   .rsp_best_coordinate (rsp_best_coordinate),
   .rsp_min_cost        (rsp_min_cost)
);

`default_nettype wire

// File: bench/weighted_median_location_checker.sv
// Checker for the weighted median location core: tracks weights, predicts results, compares.
module weighted_median_location_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_action,
   input  logic [wml_pkg::COORD_W-1:0]     req_coordinate,
   input  logic [wml_pkg::WEIGHT_IN_W-1:0] req_weight,
   input  logic                            rsp_valid,
   input  logic [wml_pkg::COORD_W-1:0]     rsp_best_coordinate,
   input  logic [wml_pkg::COST_W-1:0]      rsp_min_cost,
   output int                              fail_count,
   output int                              result_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import wml_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] coordinate;
      logic [COST_W-1:0]  cost;
   } location_type;

   // only occupied (nonzero) coordinates are kept
   logic [WEIGHT_W-1:0] weight_by_coordinate [int];
   location_type        expected_locations [$];

   function automatic logic [WEIGHT_W-1:0] add_saturated(input logic [WEIGHT_W-1:0] a,
                                                         input logic [WEIGHT_W-1:0] b);
      logic [WEIGHT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WEIGHT_W] ? WEIGHT_MAX : s[WEIGHT_W-1:0];
   endfunction

   function automatic location_type locate_median();
      int                  coords [$];
      logic [63:0]         left_cost [$];
      logic [WEIGHT_W-1:0] run_sum;
      logic [63:0]         run_cost;
      logic [63:0]         total;
      logic [63:0]         best;
      int                  best_at;
      location_type        loc;
      foreach (weight_by_coordinate[k]) coords.push_back(k);
      run_sum  = '0;
      run_cost = '0;
      foreach (coords[i]) begin
         if (i > 0) run_cost += 64'(run_sum) * 64'(coords[i] - coords[i-1]);
         left_cost.push_back(run_cost);
         run_sum = add_saturated(run_sum, weight_by_coordinate[coords[i]]);
      end
      run_sum  = '0;
      run_cost = '0;
      best     = 64'(EMPTY_COST);
      best_at  = int'(LAST_IDX);
      for (int i = coords.size() - 1; i >= 0; i--) begin
         if (i < coords.size() - 1)
            run_cost += 64'(run_sum) * 64'(coords[i+1] - coords[i]);
         run_sum = add_saturated(run_sum, weight_by_coordinate[coords[i]]);
         total   = left_cost[i] + run_cost;
         // ties go to the lower coordinate, which the downward walk meets last
         if (i == coords.size() - 1 || total <= best) begin
            best    = total;
            best_at = coords[i];
         end
      end
      loc.coordinate = COORD_W'(best_at);
      loc.cost       = COST_W'(best);
      return loc;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      location_type want;
      if (reset) begin
         weight_by_coordinate.delete();
         expected_locations.delete();
      end else begin
         if (rsp_valid) begin
            result_count++;
            if (expected_locations.size() == 0) begin
               report_mismatch("result transaction with nothing pending",
                               64'(rsp_best_coordinate), 64'(0));
            end else begin
               want = expected_locations.pop_front();
               if (rsp_best_coordinate !== want.coordinate)
                  report_mismatch("best_coordinate", 64'(rsp_best_coordinate),
                                  64'(want.coordinate));
               if (rsp_min_cost !== want.cost)
                  report_mismatch("min_cost", 64'(rsp_min_cost), 64'(want.cost));
            end
         end
         if (start && !busy) begin
            if (req_action == ACT_COMPUTE) begin
               expected_locations.push_back(locate_median());
               weight_by_coordinate.delete();
            end else if (weight_by_coordinate.exists(int'(req_coordinate))) begin
               weight_by_coordinate[int'(req_coordinate)] =
                  add_saturated(weight_by_coordinate[int'(req_coordinate)],
                                WEIGHT_W'(req_weight));
            end else if (req_weight != '0) begin
               weight_by_coordinate[int'(req_coordinate)] = WEIGHT_W'(req_weight);
            end
         end
      end
   end

endmodule

// File: bench/weighted_median_location_core_tb.sv
// Testbench top for the weighted median location core: stimulus, timeout and verdict.
module weighted_median_location_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wml_pkg::*;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   start          = 1'b0;
   logic                   req_action     = 1'b0;
   logic [COORD_W-1:0]     req_coordinate = '0;
   logic [WEIGHT_IN_W-1:0] req_weight     = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [COORD_W-1:0]     rsp_best_coordinate;
   logic [COST_W-1:0]      rsp_min_cost;
   int                     fail_count;
   int                     result_count;
   int                     idle_pct      = 0;
   int                     add_count     = 0;
   int                     compute_count = 0;

   always #4 clock = ~clock;

   weighted_median_location_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_coordinate      (req_coordinate),
      .req_weight          (req_weight),
      .rsp_valid           (rsp_valid),
      .rsp_best_coordinate (rsp_best_coordinate),
      .rsp_min_cost        (rsp_min_cost)
   );

   weighted_median_location_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_coordinate      (req_coordinate),
      .req_weight          (req_weight),
      .rsp_valid           (rsp_valid),
      .rsp_best_coordinate (rsp_best_coordinate),
      .rsp_min_cost        (rsp_min_cost),
      .fail_count          (fail_count),
      .result_count        (result_count)
   );

   // one transaction: optional idle cycles, then hold start until busy is low at an edge
   task automatic send_transaction(input wml_action_type act, input logic [COORD_W-1:0] coord,
                                   input logic [WEIGHT_IN_W-1:0] weight);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_coordinate <= coord;
      req_weight     <= weight;
      do @(posedge clock); while (busy);
      if (act == ACT_ADD) add_count++;
      else compute_count++;
   endtask

   initial begin
      int                     batch;
      int                     random_items;
      int                     n_adds;
      int                     mode;
      int                     roll;
      logic [COORD_W-1:0]     base;
      logic [COORD_W-1:0]     coord;
      logic [WEIGHT_IN_W-1:0] weight;
      batch        = 0;
      random_items = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty store, compute fields set to nonzero junk
      send_transaction(ACT_COMPUTE, '1, '1);
      // both ends at full weight, plus a zero weight that must stay unoccupied
      send_transaction(ACT_ADD, '0, '1);
      send_transaction(ACT_ADD, '1, '1);
      send_transaction(ACT_ADD, 15'h4000, '0);
      send_transaction(ACT_COMPUTE, '0, '0);
      // single point at the top coordinate
      send_transaction(ACT_ADD, '1, 20'd1);
      send_transaction(ACT_COMPUTE, 15'h2AAA, 20'h55555);
      // equal cost at two points, lower one wins
      send_transaction(ACT_ADD, 15'd10, 20'd5);
      send_transaction(ACT_ADD, 15'd20, 20'd5);
      send_transaction(ACT_COMPUTE, '0, '0);
      // repeated coordinate accumulates
      send_transaction(ACT_ADD, 15'd300, 20'd1);
      send_transaction(ACT_ADD, 15'd300, 20'd2);
      send_transaction(ACT_ADD, 15'd299, '0);
      send_transaction(ACT_ADD, 15'd301, 20'd3);
      send_transaction(ACT_ADD, 15'h3039, 20'hAAAAA);
      send_transaction(ACT_ADD, 15'h5555, 20'h55555);
      send_transaction(ACT_COMPUTE, 15'h5555, 20'hAAAAA);
      // only zero weights: still an empty answer
      send_transaction(ACT_ADD, 15'd77, '0);
      send_transaction(ACT_COMPUTE, '0, '0);

      // heavy weight stacked at the bottom end, light points far away
      repeat (4) send_transaction(ACT_ADD, '0, '1);
      send_transaction(ACT_ADD, '1, 20'd1);
      send_transaction(ACT_ADD, 15'd5, 20'd3);
      send_transaction(ACT_COMPUTE, '0, '0);

      // random batches of points, each closed by a compute
      while (random_items < 800 || batch < 30) begin
         case (batch % 3)
            0: idle_pct = 0;
            1: idle_pct = 74;
            default: idle_pct = 21;
         endcase
         roll = $urandom_range(99);
         if (roll < 10) n_adds = 0;
         else if (roll < 85) n_adds = $urandom_range(40, 1);
         else n_adds = $urandom_range(120, 60);
         mode = $urandom_range(2);
         base = COORD_W'($urandom);
         for (int n = 0; n < n_adds; n++) begin
            case (mode)
               0: coord = COORD_W'($urandom);
               1: coord = base + COORD_W'($urandom_range(63));
               default: coord = $urandom_range(1) ? COORD_W'($urandom_range(31))
                                                  : COORD_W'(32767 - $urandom_range(31));
            endcase
            roll = $urandom_range(99);
            if (roll < 10) weight = '0;
            else if (roll < 20) weight = '1;
            else if (roll < 30) weight = WEIGHT_IN_W'($urandom_range(15));
            else weight = WEIGHT_IN_W'($urandom);
            send_transaction(ACT_ADD, coord, weight);
         end
         send_transaction(ACT_COMPUTE, COORD_W'($urandom), WEIGHT_IN_W'($urandom));
         random_items += n_adds + 1;
         // now and then hold off until the answer is back
         if (batch % 8 == 0) begin
            start <= 1'b0;
            wait (result_count >= compute_count);
         end
         batch++;
      end
      start <= 1'b0;

      wait (result_count >= compute_count);
      repeat (16) @(posedge clock);
      $display("Covered %0d point adds and %0d computes, %0d results checked.",
               add_count, compute_count, result_count);
      $display("Included empty, tie, zero-weight, end-coordinate and repeated-coordinate cases.");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      repeat (4) #1_000_000_000;
      $display("Timeout waiting for the core");
      $display("Verification failed");
      $finish;
   end

endmodule

// File: weighted_median_location_core.f
rtl/wml_pkg.sv
rtl/wml_alu.sv
rtl/weighted_median_location_core.sv
rtl/wml_checker.sv
bench/weighted_median_location_checker.sv
bench/weighted_median_location_core_tb.sv
